// ----- hdl/bdpc_pkg.sv -----
`default_nettype none
package bdpc_pkg;

	localparam int BANDS      = 4;
	localparam int COORD_BITS = 12;

	localparam int LEVEL_W  = 8;
	localparam int RATIO_W  = 16;
	localparam int CFG_W    = 16;
	localparam int ADDR_W   = 2;
	localparam int DARK_W   = 22;
	localparam int IDX_W    = $clog2(BANDS);
	localparam int CNT_W    = $clog2(BANDS + 1);
	localparam int MULT_W   = $clog2(BANDS + 1);
	localparam int ROWS_P_W = COORD_BITS + MULT_W;
	localparam int WIN_P_W  = COORD_BITS + RATIO_W;
	localparam int RHS_W    = ROWS_P_W + WIN_P_W;
	localparam int LHS_W    = DARK_W + 16;
	localparam int CMP_W    = (RHS_W > LHS_W) ? RHS_W : LHS_W;
	localparam int SETTLE   = BANDS + 2;
	localparam int SETTLE_W = $clog2(SETTLE + 1);

	localparam logic [DARK_W-1:0] DARK_MAX = {DARK_W{1'b1}};

	localparam logic [COORD_BITS-1:0] WIDTH_RST  = COORD_BITS'(640);
	localparam logic [COORD_BITS-1:0] HEIGHT_RST = COORD_BITS'(480);
	localparam logic [LEVEL_W-1:0]    LEVEL_RST  = LEVEL_W'(60);
	localparam logic [RATIO_W-1:0]    RATIO_RST  = RATIO_W'(3277);

	// Reciprocal constants for the divisions by ten, by five and by the band count.
	localparam int RSH  = 20;
	localparam int R10  = (2 ** RSH + 9) / 10;
	localparam int R5   = (2 ** RSH + 4) / 5;
	localparam int PW   = COORD_BITS + RSH;
	localparam int BSH  = COORD_BITS + 4;
	localparam int RB   = (2 ** BSH + BANDS - 1) / BANDS;
	localparam int BPW  = COORD_BITS + BSH;

	typedef logic [COORD_BITS-1:0] coord_t;

	typedef enum logic [ADDR_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_DARK_LEVEL   = 2'd2,
		REG_DARK_RATIO   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		coord_t               width;
		coord_t               height;
		logic [LEVEL_W-1:0]   dark_level;
		logic [RATIO_W-1:0]   dark_ratio;
	} cfg_t;

	typedef struct packed {
		coord_t [BANDS-1:0] win_start;
		coord_t [BANDS-1:0] win_width;
		coord_t             band_rows;
		coord_t [BANDS-1:0] band_bound;
	} geom_t;

	typedef struct packed {
		logic pix_accept;
		logic eval_mul1;
		logic eval_mul2;
		logic eval_cmp;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic frame_end;
		logic band_clear;
		logic last_band;
	} sts_t;

	function automatic coord_t div10(coord_t x);
		logic [PW-1:0] p;
		p = PW'(x) * PW'(R10);
		return coord_t'(p >> RSH);
	endfunction

	function automatic coord_t four_fifths(coord_t x);
		logic [PW-1:0] p;
		p = (PW'(x) << 2) * PW'(R5);
		return coord_t'(p >> RSH);
	endfunction

	function automatic coord_t div_bands(coord_t x);
		logic [BPW-1:0] p;
		p = BPW'(x) * BPW'(RB);
		return coord_t'(p >> BSH);
	endfunction

endpackage
`default_nettype wire

// ----- hdl/bdpc_cfg.sv -----
`default_nettype none
module bdpc_cfg (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_we,
	input  wire  [bdpc_pkg::ADDR_W-1:0]   cfg_addr,
	input  wire  [bdpc_pkg::CFG_W-1:0]    cfg_wdata,
	output bdpc_pkg::cfg_t                cfg,
	output bdpc_pkg::geom_t               geom
);

	bdpc_pkg::coord_t                   width_q;
	bdpc_pkg::coord_t                   height_q;
	logic [bdpc_pkg::LEVEL_W-1:0]       level_q;
	logic [bdpc_pkg::RATIO_W-1:0]       ratio_q;
	bdpc_pkg::coord_t [bdpc_pkg::BANDS-1:0] start_q;
	bdpc_pkg::coord_t [bdpc_pkg::BANDS-1:0] wid_q;
	bdpc_pkg::coord_t                   rows_q;
	bdpc_pkg::coord_t [bdpc_pkg::BANDS-1:0] bound_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bdpc_pkg::WIDTH_RST;
			height_q <= bdpc_pkg::HEIGHT_RST;
			level_q  <= bdpc_pkg::LEVEL_RST;
			ratio_q  <= bdpc_pkg::RATIO_RST;
		end else if (cfg_we) begin
			unique case (bdpc_pkg::reg_idx_t'(cfg_addr))
				bdpc_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_wdata[bdpc_pkg::COORD_BITS-1:0];
				bdpc_pkg::REG_FRAME_HEIGHT: height_q <= cfg_wdata[bdpc_pkg::COORD_BITS-1:0];
				bdpc_pkg::REG_DARK_LEVEL:   level_q  <= cfg_wdata[bdpc_pkg::LEVEL_W-1:0];
				bdpc_pkg::REG_DARK_RATIO:   ratio_q  <= cfg_wdata[bdpc_pkg::RATIO_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.width      = (width_q == '0) ? bdpc_pkg::coord_t'(1) : width_q;
	assign cfg.height     = (height_q == '0) ? bdpc_pkg::coord_t'(1) : height_q;
	assign cfg.dark_level = level_q;
	assign cfg.dark_ratio = ratio_q;

	// Each band's window is derived from the one below it, one band per register.
	always_ff @(posedge clk) begin
		start_q[0] <= '0;
		wid_q[0]   <= cfg.width;
		for (int k = 1; k < bdpc_pkg::BANDS; k++) begin
			start_q[k] <= start_q[k-1] + bdpc_pkg::div10(wid_q[k-1]);
			wid_q[k]   <= bdpc_pkg::four_fifths(wid_q[k-1]);
		end
		rows_q <= bdpc_pkg::div_bands(cfg.height);
		for (int j = 0; j < bdpc_pkg::BANDS; j++) begin
			bound_q[j] <= bdpc_pkg::coord_t'(rows_q * (bdpc_pkg::coord_t'(j) + 1'b1));
		end
	end

	assign geom.win_start  = start_q;
	assign geom.win_width  = wid_q;
	assign geom.band_rows  = rows_q;
	assign geom.band_bound = bound_q;

endmodule
`default_nettype wire

// ----- hdl/bdpc_datapath.sv -----
`default_nettype none
module bdpc_datapath (
	input  wire                            clk,
	input  wire                            arst_n,
	input  bdpc_pkg::cfg_t                 cfg,
	input  bdpc_pkg::geom_t                geom,
	input  bdpc_pkg::cmd_t                 cmd,
	output bdpc_pkg::sts_t                 sts,
	input  wire  [bdpc_pkg::LEVEL_W-1:0]   pixel,
	output logic                           go_forward,
	output logic [2:0]                     clear_bands
);

	bdpc_pkg::coord_t                   col_q;
	bdpc_pkg::coord_t                   row_q;
	logic [bdpc_pkg::DARK_W-1:0]        dark_q [bdpc_pkg::BANDS];
	logic [bdpc_pkg::IDX_W-1:0]         idx_q;
	logic [bdpc_pkg::CNT_W-1:0]         clear_q;
	logic [bdpc_pkg::ROWS_P_W-1:0]      rows_p_s1;
	logic [bdpc_pkg::WIN_P_W-1:0]       win_p_s1;
	logic [bdpc_pkg::RHS_W-1:0]         rhs_s2;

	logic [bdpc_pkg::IDX_W-1:0]         band_top;
	logic [bdpc_pkg::IDX_W-1:0]         pix_idx;
	logic                               in_bands;
	logic                               in_win;
	logic                               dark_hit;
	logic                               row_end;
	logic                               frame_end;
	bdpc_pkg::coord_t                   start;
	bdpc_pkg::coord_t                   wid;
	logic [bdpc_pkg::CMP_W-1:0]         lhs;
	logic [3:0]                         clear4;

	always_comb begin
		band_top = '0;
		for (int j = 1; j < bdpc_pkg::BANDS; j++) begin
			if (row_q >= geom.band_bound[j-1]) begin
				band_top = band_top + bdpc_pkg::IDX_W'(1);
			end
		end
	end

	assign pix_idx   = bdpc_pkg::IDX_W'(bdpc_pkg::BANDS - 1) - band_top;
	assign in_bands  = row_q < geom.band_bound[bdpc_pkg::BANDS-1];
	assign start     = geom.win_start[pix_idx];
	assign wid       = geom.win_width[pix_idx];
	assign in_win    = (col_q >= start) && ({1'b0, col_q} < ({1'b0, start} + {1'b0, wid}));
	assign dark_hit  = in_bands && in_win && (pixel < cfg.dark_level);
	assign row_end   = col_q >= (cfg.width - bdpc_pkg::coord_t'(1));
	assign frame_end = row_end && (row_q >= (cfg.height - bdpc_pkg::coord_t'(1)));

	assign lhs = bdpc_pkg::CMP_W'(dark_q[idx_q]) << 16;

	assign sts.frame_end  = frame_end;
	assign sts.band_clear = lhs < bdpc_pkg::CMP_W'(rhs_s2);
	assign sts.last_band  = idx_q == bdpc_pkg::IDX_W'(bdpc_pkg::BANDS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			idx_q   <= '0;
			clear_q <= '0;
			for (int k = 0; k < bdpc_pkg::BANDS; k++) begin
				dark_q[k] <= '0;
			end
		end else begin
			if (cmd.pix_accept) begin
				if (dark_hit && dark_q[pix_idx] != bdpc_pkg::DARK_MAX) begin
					dark_q[pix_idx] <= dark_q[pix_idx] + 1'b1;
				end
				col_q <= row_end ? '0 : col_q + 1'b1;
				if (row_end) begin
					row_q <= frame_end ? '0 : row_q + 1'b1;
				end
				if (frame_end) begin
					idx_q   <= '0;
					clear_q <= '0;
				end
			end
			if (cmd.eval_cmp) begin
				if (sts.band_clear) begin
					clear_q <= clear_q + 1'b1;
				end
				if (!sts.last_band) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (cmd.load_out) begin
				for (int k = 0; k < bdpc_pkg::BANDS; k++) begin
					dark_q[k] <= '0;
				end
			end
		end
	end

	assign clear4 = 4'(clear_q);

	// Right-hand side of the clear test: rows times band weight, window times ratio, then both.
	always_ff @(posedge clk) begin
		if (cmd.eval_mul1) begin
			rows_p_s1 <= bdpc_pkg::ROWS_P_W'(geom.band_rows) *
				bdpc_pkg::ROWS_P_W'(bdpc_pkg::MULT_W'(bdpc_pkg::BANDS) -
				bdpc_pkg::MULT_W'(idx_q));
			win_p_s1  <= bdpc_pkg::WIN_P_W'(geom.win_width[idx_q]) *
				bdpc_pkg::WIN_P_W'(cfg.dark_ratio);
		end
		if (cmd.eval_mul2) begin
			rhs_s2 <= bdpc_pkg::RHS_W'(rows_p_s1) * bdpc_pkg::RHS_W'(win_p_s1);
		end
		if (cmd.load_out) begin
			go_forward  <= {1'b0, clear4} << 1 >= 5'(bdpc_pkg::BANDS);
			clear_bands <= (clear4 > 4'd7) ? 3'd7 : clear4[2:0];
		end
	end

endmodule
`default_nettype wire

// ----- hdl/bdpc_ctrl.sv -----
`default_nettype none
module bdpc_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_we,
	input  wire                 s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  wire                 m_tready,
	input  bdpc_pkg::sts_t      sts,
	output bdpc_pkg::cmd_t      cmd
);

	typedef enum logic [4:0] {
		ST_RUN  = 5'b00001,
		ST_MUL1 = 5'b00010,
		ST_MUL2 = 5'b00100,
		ST_CMP  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t                             state_q;
	state_t                             state_d;
	logic [bdpc_pkg::SETTLE_W-1:0]      settle_q;
	logic                               m_valid_q;
	logic                               accept;

	assign s_tready = (state_q == ST_RUN) && (settle_q == '0);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_valid_q;

	assign cmd.pix_accept = accept;
	assign cmd.eval_mul1  = state_q == ST_MUL1;
	assign cmd.eval_mul2  = state_q == ST_MUL2;
	assign cmd.eval_cmp   = state_q == ST_CMP;
	assign cmd.load_out   = (state_q == ST_DONE) && (!m_valid_q || m_tready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_RUN: begin
				if (accept && sts.frame_end) begin
					state_d = ST_MUL1;
				end
			end
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_CMP;
			ST_CMP: begin
				state_d = (sts.band_clear && !sts.last_band) ? ST_MUL1 : ST_DONE;
			end
			ST_DONE: begin
				if (cmd.load_out) begin
					state_d = ST_RUN;
				end
			end
			default: state_d = ST_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_RUN;
			settle_q  <= bdpc_pkg::SETTLE_W'(bdpc_pkg::SETTLE);
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				settle_q <= bdpc_pkg::SETTLE_W'(bdpc_pkg::SETTLE);
			end else if (settle_q != '0) begin
				settle_q <= settle_q - 1'b1;
			end
			if (cmd.load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ----- hdl/banded_dark_pixel_path_check_unit.sv -----
// Channel   Direction  Contents (lowest bit first)
// cfg       in         cfg_we, cfg_addr register index, cfg_wdata value
// s_axis    in         s_tdata: pixel[7:0]
// m_axis    out        m_tdata: go_forward[0], clear_bands[3:1], zero[7:4]
//
// A pixel request is taken when s_tvalid and s_tready are both high. The frame's last
// pixel starts a band walk through two multiplier stages and a compare per band, stopping
// after the first band that is not clear, and the result is then posted once the previous
// result has been taken. Pixels wait during the walk and the posting; a posted result does
// not hold them off. After reset and after every configuration write s_tready is low while
// the window chain settles. Reset is asynchronous and active low.
`default_nettype none
module banded_dark_pixel_path_check_unit (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_we,
	input  wire  [bdpc_pkg::ADDR_W-1:0]   cfg_addr,
	input  wire  [bdpc_pkg::CFG_W-1:0]    cfg_wdata,
	input  wire                           s_tvalid,
	output logic                          s_tready,
	input  wire  [7:0]                    s_tdata,   // pixel[7:0]
	output logic                          m_tvalid,
	input  wire                           m_tready,
	output logic [7:0]                    m_tdata    // go_forward[0], clear_bands[3:1]
);

	bdpc_pkg::cfg_t   cfg;
	bdpc_pkg::geom_t  geom;
	bdpc_pkg::cmd_t   cmd;
	bdpc_pkg::sts_t   sts;
	logic             go_forward;
	logic [2:0]       clear_bands;

	bdpc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg),
		.geom      (geom)
	);

	bdpc_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.geom        (geom),
		.cmd         (cmd),
		.sts         (sts),
		.pixel       (s_tdata),
		.go_forward  (go_forward),
		.clear_bands (clear_bands)
	);

	bdpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	assign m_tdata = {4'b0000, clear_bands, go_forward};

endmodule
`default_nettype wire

// ----- hdl/bdpc_checker.sv -----
`default_nettype none
module bdpc_checker (
	input wire                           clk,
	input wire                           arst_n,
	input wire                           cfg_we,
	input wire                           s_tready,
	input wire                           m_tvalid,
	input wire                           m_tready,
	input wire [7:0]                     m_tdata
);

	// A result request that is held keeps its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("held result changed");

	// The go flag agrees with the number of clear bands.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[0] == ({1'b0, m_tdata[3:1], 1'b0} >= 5'(bdpc_pkg::BANDS)))
		else $error("go flag disagrees with clear band count");

	// No more bands can be clear than there are.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> 4'(m_tdata[3:1]) <= 4'(bdpc_pkg::BANDS))
		else $error("clear band count out of range");

	// A configuration write holds off pixels while the windows are recomputed.
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !s_tready)
		else $error("pixel accepted straight after a configuration write");

	// A result is only posted after a band walk, during which no pixel was taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result posted without a band walk");

endmodule

bind banded_dark_pixel_path_check_unit bdpc_checker u_bdpc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.cfg_we   (cfg_we),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire
